### rtl/core/rwr_pkg.sv
// shared constants, defaults and sequencer state type for the reorder window receiver
package rwr_pkg;

  localparam int unsigned SEQ_BITS = 3;
  localparam int unsigned ACK_BITS = 4;

  localparam int unsigned SEQ_MODULUS_DEF  = 8;
  localparam int unsigned AHEAD_SLOTS_DEF  = 3;
  localparam int unsigned PAYLOAD_BITS_DEF = 64;

  // ack value before anything has been delivered (minus one)
  localparam logic signed [ACK_BITS-1:0] ACK_NONE = '1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FIRST,
    ST_EMIT,
    ST_ACK
  } rwr_state_e;

endpackage

### rtl/core/rwr_if.sv
// valid/ready channel interfaces for incoming packets and outgoing results
interface rwr_in_if #(
  parameter int unsigned PAYLOAD_BITS = rwr_pkg::PAYLOAD_BITS_DEF
);
  import rwr_pkg::*;

  logic                    valid;
  logic                    ready;
  logic                    checksum_good;
  logic [SEQ_BITS-1:0]     seq_num;
  logic [PAYLOAD_BITS-1:0] payload;

  modport source (output valid, checksum_good, seq_num, payload, input ready);
  modport sink   (input valid, checksum_good, seq_num, payload, output ready);
endinterface

interface rwr_out_if #(
  parameter int unsigned PAYLOAD_BITS = rwr_pkg::PAYLOAD_BITS_DEF
);
  import rwr_pkg::*;

  logic                       valid;
  logic                       ready;
  logic                       is_ack;
  logic [PAYLOAD_BITS-1:0]    data_out;
  logic signed [ACK_BITS-1:0] ack_number;
  logic                       last_of_run;

  modport source (output valid, is_ack, data_out, ack_number, last_of_run, input ready);
  modport sink   (input valid, is_ack, data_out, ack_number, last_of_run, output ready);
endinterface

### rtl/core/rwr_ram.sv
// generic single write port, single read port ram with registered read
module rwr_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 8,
  localparam int unsigned AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/core/reorder_window_receiver.sv
// top level of the reorder window receiver: window sequencer around the payload ram
//
//  channel | dir | payload                                         | transaction
//  pkt_i   | in  | checksum_good, seq_num, payload                 | one arriving packet
//  res_o   | out | is_ack, data_out, ack_number, last_of_run       | one delivery or ack
//
//  a stored or dropped packet goes from idle to ack; an in order packet goes from
//  idle to first, one emit per buffered payload it releases (up to AHEAD_SLOTS), ack
//  the sequencer emits one result per cycle while the result register is free; the
//  payload ram read is addressed with the next position, ready for the emit state
//  reset clears the expected number, the ack (to minus one) and all valid bits
//  a stalled result register holds the sequencer; a new packet is taken only
//  once the ack of the previous one sits in the result register
module reorder_window_receiver #(
  parameter int unsigned SEQ_MODULUS  = rwr_pkg::SEQ_MODULUS_DEF,
  parameter int unsigned AHEAD_SLOTS  = rwr_pkg::AHEAD_SLOTS_DEF,
  parameter int unsigned PAYLOAD_BITS = rwr_pkg::PAYLOAD_BITS_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  rwr_in_if.sink     pkt_i,
  rwr_out_if.source  res_o
);
  import rwr_pkg::*;

  localparam int unsigned PosW  = $clog2(SEQ_MODULUS);
  localparam int unsigned DistW = PosW + 1;
  localparam int unsigned CntW  = $clog2(AHEAD_SLOTS + 1);

  // step a window position forward, wrapping at the modulus
  function automatic logic [PosW-1:0] pos_inc(input logic [PosW-1:0] p);
    logic [PosW-1:0] r;
    if (p == PosW'(SEQ_MODULUS - 1)) begin
      r = '0;
    end else begin
      r = p + 1'b1;
    end
    return r;
  endfunction

  // sequencer state
  rwr_state_e state_q, state_d;

  // window state: expected number, last ack, per-position valid bits
  logic [PosW-1:0]            exp_q, exp_d;
  logic signed [ACK_BITS-1:0] last_ack_q, last_ack_d;
  logic [SEQ_MODULUS-1:0]     valid_q, valid_d;

  // delivery run: position being drained and buffered payloads released so far
  logic [PosW-1:0]         pos_q, pos_d;
  logic [CntW-1:0]         nbuf_q, nbuf_d;
  logic [PAYLOAD_BITS-1:0] hold_q, hold_d;

  // result register
  logic                       res_valid_q, res_valid_d;
  logic                       res_is_ack_q, res_is_ack_d;
  logic [PAYLOAD_BITS-1:0]    res_data_q, res_data_d;
  logic signed [ACK_BITS-1:0] res_ack_q, res_ack_d;
  logic                       res_last_q, res_last_d;

  // payload ram port signals
  logic                    ram_we;
  logic [PAYLOAD_BITS-1:0] ram_rdata;

  // packet classification
  logic [PosW-1:0]  seq_pos;
  logic             seq_ok;
  logic [DistW-1:0] ahead;
  logic             in_order;
  logic             in_window;
  logic [PosW-1:0]  pos_next;
  logic [PosW-1:0]  exp_next;
  logic             more_after_emit;
  logic             can_load;

  assign seq_pos  = PosW'(pkt_i.seq_num);
  assign seq_ok   = pkt_i.checksum_good && (32'(pkt_i.seq_num) < SEQ_MODULUS);
  // distance ahead of the expected number, modulo the sequence space
  assign ahead    = (seq_pos >= exp_q) ? (DistW'(seq_pos) - DistW'(exp_q))
                  : (DistW'(seq_pos) + DistW'(SEQ_MODULUS) - DistW'(exp_q));
  assign in_order  = seq_ok && (ahead == '0);
  assign in_window = seq_ok && (ahead != '0) && (32'(ahead) <= AHEAD_SLOTS);

  assign pos_next = pos_inc(pos_q);
  assign exp_next = pos_inc(exp_q);
  // another contiguous buffered payload follows the one leaving now
  assign more_after_emit = ((32'(nbuf_q) + 1) < AHEAD_SLOTS) && valid_q[pos_next];

  // result register is free this cycle
  assign can_load = !res_valid_q || res_o.ready;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (pkt_i.valid) begin
          state_d = in_order ? ST_FIRST : ST_ACK;
        end
      end
      ST_FIRST: begin
        if (can_load) begin
          state_d = valid_q[pos_q] ? ST_EMIT : ST_ACK;
        end
      end
      ST_EMIT: begin
        if (can_load) begin
          state_d = more_after_emit ? ST_EMIT : ST_ACK;
        end
      end
      ST_ACK: begin
        if (can_load) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // datapath and outputs
  always_comb begin
    pkt_i.ready  = (state_q == ST_IDLE);
    exp_d        = exp_q;
    last_ack_d   = last_ack_q;
    valid_d      = valid_q;
    pos_d        = pos_q;
    nbuf_d       = nbuf_q;
    hold_d       = hold_q;
    ram_we       = 1'b0;
    res_valid_d  = res_valid_q && !res_o.ready;
    res_is_ack_d = res_is_ack_q;
    res_data_d   = res_data_q;
    res_ack_d    = res_ack_q;
    res_last_d   = res_last_q;

    case (state_q)
      ST_IDLE: begin
        if (pkt_i.valid) begin
          if (in_order) begin
            // start a run; the first buffered candidate sits right after it
            hold_d = pkt_i.payload;
            pos_d  = exp_next;
            nbuf_d = '0;
          end
          if (in_window) begin
            ram_we          = 1'b1;
            valid_d[seq_pos] = 1'b1;
          end
        end
      end
      ST_FIRST: begin
        if (can_load) begin
          res_valid_d  = 1'b1;
          res_is_ack_d = 1'b0;
          res_data_d   = hold_q;
          res_ack_d    = '0;
          res_last_d   = 1'b0;
          if (!valid_q[pos_q]) begin
            exp_d      = pos_q;
            last_ack_d = $signed(ACK_BITS'(pos_q));
          end
        end
      end
      ST_EMIT: begin
        if (can_load) begin
          res_valid_d    = 1'b1;
          res_is_ack_d   = 1'b0;
          res_data_d     = ram_rdata;
          res_ack_d      = '0;
          res_last_d     = 1'b0;
          valid_d[pos_q] = 1'b0;
          pos_d          = pos_next;
          nbuf_d         = nbuf_q + 1'b1;
          if (!more_after_emit) begin
            exp_d      = pos_next;
            last_ack_d = $signed(ACK_BITS'(pos_next));
          end
        end
      end
      ST_ACK: begin
        if (can_load) begin
          res_valid_d  = 1'b1;
          res_is_ack_d = 1'b1;
          res_data_d   = '0;
          res_ack_d    = last_ack_q;
          res_last_d   = 1'b1;
        end
      end
      default: begin
        res_valid_d = res_valid_q && !res_o.ready;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      exp_q       <= '0;
      last_ack_q  <= ACK_NONE;
      valid_q     <= '0;
      pos_q       <= '0;
      nbuf_q      <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      exp_q       <= exp_d;
      last_ack_q  <= last_ack_d;
      valid_q     <= valid_d;
      pos_q       <= pos_d;
      nbuf_q      <= nbuf_d;
      res_valid_q <= res_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    hold_q       <= hold_d;
    res_is_ack_q <= res_is_ack_d;
    res_data_q   <= res_data_d;
    res_ack_q    <= res_ack_d;
    res_last_q   <= res_last_d;
  end

  // payload store indexed by sequence position; read issued the cycle before use
  rwr_ram #(
    .WIDTH (PAYLOAD_BITS),
    .DEPTH (SEQ_MODULUS)
  ) u_payload_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (seq_pos),
    .wdata_i (pkt_i.payload),
    .raddr_i (pos_d),
    .rdata_o (ram_rdata)
  );

  assign res_o.valid       = res_valid_q;
  assign res_o.is_ack      = res_is_ack_q;
  assign res_o.data_out    = res_data_q;
  assign res_o.ack_number  = res_ack_q;
  assign res_o.last_of_run = res_last_q;

`ifndef SYNTHESIS
  // the expected position itself is never held in the reorder buffer
  a_expected_not_buffered: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !valid_q[exp_q])
    else $error("expected sequence position marked as buffered");

  // the final result of a packet is always the ack and only the ack
  a_last_is_ack: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid |-> (res_o.last_of_run == res_o.is_ack))
    else $error("last_of_run does not match is_ack");

  // a run never releases more buffered payloads than there are slots
  a_run_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (32'(nbuf_q) <= AHEAD_SLOTS))
    else $error("delivery run exceeded the window");

  // a drained buffered slot is cleared in the cycle it leaves
  a_emit_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EMIT && can_load) |=> !valid_q[$past(pos_q)])
    else $error("delivered slot still marked valid");
`endif

endmodule

### dv/rwr_delivery_tracker.sv
`timescale 1ns / 100ps
// watches both channels of the reorder window receiver, predicts each result and compares it
module rwr_delivery_tracker
  import rwr_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  rwr_in_if                   pkt_i,
  rwr_out_if                  res_i,
  output int unsigned         mismatch_count_o,
  output int unsigned         due_count_o,
  output logic [SEQ_BITS-1:0] next_seq_o,
  output int unsigned         delivered_count_o,
  output int unsigned         stored_count_o,
  output int unsigned         ack_count_o
);

  localparam int unsigned REPORT_LIMIT = 40;

  typedef struct packed {
    logic                        is_ack;
    logic [PAYLOAD_BITS_DEF-1:0] data_out;
    logic signed [ACK_BITS-1:0]  ack_number;
    logic                        last_of_run;
  } rwr_result_t;

  logic [SEQ_BITS-1:0]         want_seq;
  logic signed [ACK_BITS-1:0]  ack_now;
  logic [AHEAD_SLOTS_DEF-1:0]  slot_full;
  logic [PAYLOAD_BITS_DEF-1:0] slot_data [AHEAD_SLOTS_DEF];
  rwr_result_t                 due_q [$];

  int unsigned mismatches = 0;
  int unsigned delivered  = 0;
  int unsigned stored     = 0;
  int unsigned acks       = 0;

  function automatic void flag_field(input string field, input logic [63:0] want,
                                     input logic [63:0] got);
    mismatches++;
    if (mismatches <= REPORT_LIMIT)
      $error("%s: expected %0h, got %0h", field, want, got);
  endfunction

  // one arriving packet: deliveries in order, then the cumulative ack
  task automatic window_step(input logic good, input logic [SEQ_BITS-1:0] seq,
                             input logic [PAYLOAD_BITS_DEF-1:0] pay);
    int unsigned ahead;
    int unsigned run;
    int unsigned j;
    ahead = (seq + SEQ_MODULUS_DEF - want_seq) % SEQ_MODULUS_DEF;
    if (good === 1'b1) begin
      if (ahead == 0) begin
        due_q.push_back(rwr_result_t'{1'b0, pay, '0, 1'b0});
        delivered++;
        run = 1;
        while (run <= AHEAD_SLOTS_DEF && slot_full[run-1]) begin
          due_q.push_back(rwr_result_t'{1'b0, slot_data[run-1], '0, 1'b0});
          delivered++;
          run++;
        end
        want_seq = SEQ_BITS'((want_seq + run) % SEQ_MODULUS_DEF);
        ack_now  = ACK_BITS'(want_seq);
        for (j = 0; j < AHEAD_SLOTS_DEF; j++) begin
          if (j + run < AHEAD_SLOTS_DEF) begin
            slot_full[j] = slot_full[j+run];
            slot_data[j] = slot_data[j+run];
          end else begin
            slot_full[j] = 1'b0;
          end
        end
      end else if (ahead <= AHEAD_SLOTS_DEF) begin
        slot_data[ahead-1] = pay;
        slot_full[ahead-1] = 1'b1;
        stored++;
      end
    end
    due_q.push_back(rwr_result_t'{1'b1, '0, ack_now, 1'b1});
    acks++;
  endtask

  task automatic check_result();
    rwr_result_t want;
    if (due_q.size() == 0) begin
      mismatches++;
      if (mismatches <= REPORT_LIMIT)
        $error("result with nothing outstanding: is_ack %0b data_out %0h ack_number %0h",
               res_i.is_ack, res_i.data_out, res_i.ack_number);
      return;
    end
    want = due_q.pop_front();
    if (res_i.is_ack !== want.is_ack)
      flag_field("is_ack", 64'(want.is_ack), 64'(res_i.is_ack));
    if (res_i.data_out !== want.data_out)
      flag_field("data_out", want.data_out, res_i.data_out);
    if (res_i.ack_number !== want.ack_number)
      flag_field("ack_number", 64'(unsigned'(want.ack_number)),
                 64'(unsigned'(res_i.ack_number)));
    if (res_i.last_of_run !== want.last_of_run)
      flag_field("last_of_run", 64'(want.last_of_run), 64'(res_i.last_of_run));
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      want_seq  = '0;
      ack_now   = ACK_NONE;
      slot_full = '0;
      due_q.delete();
    end else begin
      if (res_i.valid === 1'b1 && res_i.ready === 1'b1) check_result();
      if (pkt_i.valid === 1'b1 && pkt_i.ready === 1'b1)
        window_step(pkt_i.checksum_good, pkt_i.seq_num, pkt_i.payload);
    end
    mismatch_count_o  <= mismatches;
    due_count_o       <= due_q.size();
    next_seq_o        <= want_seq;
    delivered_count_o <= delivered;
    stored_count_o    <= stored;
    ack_count_o       <= acks;
  end

endmodule

### dv/reorder_window_receiver_test.sv
`timescale 1ns / 100ps
// stimulus, handshake pacing and verdict for the reorder window receiver
module reorder_window_receiver_test;
  import rwr_pkg::*;

  localparam int unsigned PACKET_TARGET = 470;
  localparam int unsigned HOLD_CYCLES   = 160;
  localparam int unsigned SETTLE_CYCLES = 12;
  // worst case is far below this: five results per packet, each behind a long stall
  localparam int unsigned CYCLE_LIMIT   = 600000;

  logic clk_i;
  logic rst_ni;

  rwr_in_if  pkt_if ();
  rwr_out_if res_if ();

  // what the tracker reports back
  int unsigned         mismatches;
  int unsigned         outstanding;
  int unsigned         delivered;
  int unsigned         stored;
  int unsigned         acks;
  logic [SEQ_BITS-1:0] want_seq;

  // pacing shared by the two sides
  bit          no_idle = 1'b0;  // both sides run flat out
  int unsigned hold_asked  = 0; // bumped by the sender to ask for a long hold-off
  int unsigned hold_served = 0; // bumped by the receiver once a hold-off is done

  int unsigned sent   = 0;
  int unsigned cycles = 0;

  // bookkeeping for the closing summary
  int unsigned window_bursts = 0;
  int unsigned noise_bursts  = 0;
  int unsigned straight_runs = 0;
  int unsigned drains        = 0;

  reorder_window_receiver u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .pkt_i  (pkt_if),
    .res_o  (res_if)
  );

  rwr_delivery_tracker u_tracker (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .pkt_i             (pkt_if),
    .res_i             (res_if),
    .mismatch_count_o  (mismatches),
    .due_count_o       (outstanding),
    .next_seq_o        (want_seq),
    .delivered_count_o (delivered),
    .stored_count_o    (stored),
    .ack_count_o       (acks)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // gap lengths: mostly none or short, now and then a long one
  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // payloads: mostly random, sometimes all zeros or all ones
  function automatic logic [PAYLOAD_BITS_DEF-1:0] rand_payload();
    case ($urandom_range(0, 15))
      0:       return '0;
      1:       return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // offer one packet, hold it until the block takes it, then maybe idle
  // closes forces an idle gap after the packet, so the next read of the predicted
  // window base sees this transaction already folded in
  task automatic offer_packet(input logic good, input logic [SEQ_BITS-1:0] seq,
                              input logic [PAYLOAD_BITS_DEF-1:0] pay, input bit closes);
    int unsigned idle;
    pkt_if.valid         <= 1'b1;
    pkt_if.checksum_good <= good;
    pkt_if.seq_num       <= seq;
    pkt_if.payload       <= pay;
    @(posedge clk_i);
    while (pkt_if.ready !== 1'b1) @(posedge clk_i);
    sent++;
    idle = no_idle ? 0 : pick_gap();
    if (closes && idle == 0) idle = 1;
    if (idle != 0) begin
      pkt_if.valid <= 1'b0;
      repeat (idle) @(posedge clk_i);
    end
  endtask

  // sender stays quiet until every predicted result has come out
  task automatic wait_drained();
    while (outstanding != 0) @(posedge clk_i);
  endtask

  // a well-formed window: the packets from the expected number up to three
  // ahead, shuffled; sometimes the base packet is lost (the rest just sits in
  // the slots), sometimes one is repeated, sometimes a stray packet slips in
  task automatic window_burst();
    logic [SEQ_BITS-1:0] base;
    logic [SEQ_BITS-1:0] seqs [$];
    logic [SEQ_BITS-1:0] swap;
    int                  i;
    int                  k;
    int unsigned         span;
    int unsigned         roll;
    base = want_seq;
    span = $urandom_range(1, AHEAD_SLOTS_DEF + 1);
    roll = $urandom_range(0, 99);
    for (i = 0; i < span; i++) begin
      if (!(roll < 20 && i == 0)) seqs.push_back(base + SEQ_BITS'(i));
    end
    if (seqs.size() == 0 || $urandom_range(0, 9) == 0)
      seqs.push_back(SEQ_BITS'($urandom_range(0, SEQ_MODULUS_DEF - 1)));
    if (roll >= 20 && roll < 35) seqs.push_back(seqs[$urandom_range(0, seqs.size() - 1)]);
    for (i = seqs.size() - 1; i > 0; i--) begin
      k       = $urandom_range(0, i);
      swap    = seqs[i];
      seqs[i] = seqs[k];
      seqs[k] = swap;
    end
    for (i = 0; i < seqs.size(); i++)
      offer_packet($urandom_range(0, 19) != 0, seqs[i], rand_payload(), i == seqs.size() - 1);
    window_bursts++;
  endtask

  // straight run of consecutive sequence numbers from the current base with no_idle set
  task automatic straight_run(input int unsigned count);
    logic [SEQ_BITS-1:0] seq;
    int unsigned         i;
    seq     = want_seq;
    no_idle = 1'b1;
    for (i = 0; i < count; i++) begin
      offer_packet($urandom_range(0, 15) != 0, seq, rand_payload(), i == count - 1);
      seq++;
    end
    no_idle = 1'b0;
    straight_runs++;
  endtask

  // receiver: ready pattern with its own gaps, plus the long hold-off on request
  initial begin
    int unsigned stall;
    res_if.ready <= 1'b0;
    @(posedge clk_i);
    forever begin
      if (hold_asked != hold_served) begin
        // long hold-off: the result register stays full, the sequencer stalls and the block stops taking packets
        res_if.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_served++;
      end else if (no_idle) begin
        res_if.ready <= 1'b1;
        @(posedge clk_i);
      end else begin
        res_if.ready <= 1'b1;
        repeat (pick_gap() + 1) @(posedge clk_i);
        stall = pick_gap();
        if (stall != 0) begin
          res_if.ready <= 1'b0;
          repeat (stall) @(posedge clk_i);
        end
      end
    end
  end

  // run limit
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $error("run limit of %0d cycles reached with %0d results outstanding",
             CYCLE_LIMIT, outstanding);
      $display("tb: failure");
      $finish;
    end
  end

  // sender and verdict
  initial begin
    int unsigned i;
    int unsigned bursts;
    pkt_if.valid         <= 1'b0;
    pkt_if.checksum_good <= 1'b0;
    pkt_if.seq_num       <= '0;
    pkt_if.payload       <= '0;
    rst_ni               <= 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed part, numbers known from reset (expected 0, ack minus one)
    // bad checksum before anything was delivered: ack stays minus one
    offer_packet(1'b0, 3'd0, '1, 1'b0);
    // fill the window out of order: three ahead, one ahead, two ahead
    offer_packet(1'b1, 3'd3, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0);
    offer_packet(1'b1, 3'd1, 64'h0000_0000_0000_0000, 1'b0);
    offer_packet(1'b1, 3'd2, 64'h8000_0000_0000_0001, 1'b0);
    // same packet buffered again: slot takes the new payload
    offer_packet(1'b1, 3'd2, 64'h5555_5555_5555_5555, 1'b0);
    // just past the window and far ahead: dropped
    offer_packet(1'b1, 3'd4, 64'h0123_4567_89AB_CDEF, 1'b0);
    offer_packet(1'b1, 3'd7, 64'hFEDC_BA98_7654_3210, 1'b0);
    // the gap closes: four deliveries and the ack, the most one packet gives
    offer_packet(1'b1, 3'd0, 64'hAAAA_AAAA_AAAA_AAAA, 1'b0);
    // duplicate of a delivered packet, then the expected one with a bad checksum
    offer_packet(1'b1, 3'd3, rand_payload(), 1'b0);
    offer_packet(1'b0, 3'd4, rand_payload(), 1'b0);
    // in order across the wrap of the sequence numbers
    for (i = 4; i < 9; i++) offer_packet(1'b1, SEQ_BITS'(i), rand_payload(), 1'b0);
    // reversed window: two stored, the third releases both
    offer_packet(1'b1, 3'd3, rand_payload(), 1'b0);
    offer_packet(1'b1, 3'd2, rand_payload(), 1'b0);
    offer_packet(1'b1, 3'd1, rand_payload(), 1'b0);
    // hole in the window: release stops at the hole, the later slot shifts down
    offer_packet(1'b1, 3'd5, rand_payload(), 1'b0);
    offer_packet(1'b1, 3'd7, rand_payload(), 1'b0);
    offer_packet(1'b1, 3'd4, rand_payload(), 1'b0);
    offer_packet(1'b1, 3'd6, rand_payload(), 1'b1);
    wait_drained();
    drains++;

    // random part: mostly windows with random content, some noise, plus the
    // hold-offs, drains and flat-out stretches spread over the run
    bursts = 0;
    while (sent < PACKET_TARGET) begin
      bursts++;
      if (bursts % 40 == 12) begin
        hold_asked++;
        straight_run(10);
      end else if (bursts % 40 == 25) begin
        wait_drained();
        drains++;
      end else if (bursts % 15 == 7) begin
        straight_run(16);
      end else if ($urandom_range(0, 99) < 75) begin
        window_burst();
      end else begin
        bursts = bursts;
        for (i = $urandom_range(1, 4); i > 0; i--)
          offer_packet(1'($urandom_range(0, 1)),
                       SEQ_BITS'($urandom_range(0, SEQ_MODULUS_DEF - 1)),
                       rand_payload(), i == 1);
        noise_bursts++;
      end
    end

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk_i);

    $display("tb: %0d packets, %0d payloads delivered, %0d stored ahead, %0d acks",
             sent, delivered, stored, acks);
    $display("tb: %0d window bursts, %0d noise bursts, %0d in-order runs, %0d hold-offs, %0d drains",
             window_bursts, noise_bursts, straight_runs, hold_served, drains);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

### reorder_window_receiver.f
rtl/core/rwr_pkg.sv
rtl/core/rwr_if.sv
rtl/core/rwr_ram.sv
rtl/core/reorder_window_receiver.sv
dv/rwr_delivery_tracker.sv
dv/reorder_window_receiver_test.sv
